/* hw/rtl/bblur_pkg.sv */
// ----------------------------------------------------------------------------
// bblur_pkg: shared types and constants for the 3x3 box blur
// Pixel and column-entry types, register indexes and divider constants.
// ----------------------------------------------------------------------------
package bblur_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  localparam int PIX_W = $bits(pix_t);

  // which neighbour rows/columns lie inside the image
  typedef struct packed {
    logic row_top;
    logic row_bot;
    logic col_left;
    logic col_right;
  } nbr_mask_t;

  // one classified beat handed from front end to back end
  typedef struct packed {
    pix_t      top;
    pix_t      mid;
    pix_t      bot;
    logic      emit;
    logic      last;
    nbr_mask_t mask;
  } col_entry_t;

  localparam int CFG_ADDR_W     = 1;
  localparam int CFG_DATA_W     = 13;
  localparam int WIDTH_FIELD_W  = 11;
  localparam int HEIGHT_FIELD_W = 13;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam int QUEUE_DEPTH = 4;

  // sum of up to nine 8-bit samples plus rounding term
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 15;
  localparam logic [RECIP_W-1:0] RECIP6 = 13'd5462;
  localparam logic [RECIP_W-1:0] RECIP9 = 13'd3641;

endpackage

/* hw/rtl/bblur_front.sv */
// ----------------------------------------------------------------------------
// bblur_front: input acceptance, position tracking and line store
// Classifies each beat, reads/updates the two-row column store and hands a
// column triple with its neighbour mask to the queue.
// ----------------------------------------------------------------------------
module bblur_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bblur_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bblur_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic [7:0]                          in_red,
  input  logic [7:0]                          in_green,
  input  logic [7:0]                          in_blue,
  input  logic                                queue_room,
  output logic                                push,
  output bblur_pkg::col_entry_t               push_data
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RST_W = (bblur_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                               : bblur_pkg::RESET_WIDTH;
  localparam int RST_H = (bblur_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                                 : bblur_pkg::RESET_HEIGHT;
  localparam int PW = bblur_pkg::PIX_W;

  logic [CW-1:0] width_reg;
  logic [RW-1:0] height_reg;
  logic [RW-1:0] in_row;
  logic [CW-1:0] in_col;
  logic [RW-1:0] out_row;
  logic [CW-1:0] out_col;

  logic [CW-1:0] width_cfg;
  logic [RW-1:0] height_cfg;
  logic [31:0]   wf32;
  logic [31:0]   hf32;

  logic                 draining;
  logic                 accept;
  logic                 live;
  logic                 emit;
  logic                 last;
  logic [RW-1:0]        out_row_inc;
  logic [CW-1:0]        out_col_inc;
  logic [CW-1:0]        in_col_inc;
  bblur_pkg::nbr_mask_t mask;

  logic                 s1_valid;
  logic                 s1_wr;
  logic [AW-1:0]        s1_col;
  bblur_pkg::pix_t      s1_pix;
  logic                 s1_emit;
  logic                 s1_last;
  bblur_pkg::nbr_mask_t s1_mask;

  // each entry holds {row two above, row above} for one column
  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] line_rdata;

  always_comb begin
    wf32 = 32'(cfg_wdata[bblur_pkg::WIDTH_FIELD_W-1:0]);
    hf32 = 32'(cfg_wdata[bblur_pkg::HEIGHT_FIELD_W-1:0]);
    if (wf32 < 32'd2) begin
      width_cfg = CW'(2);
    end else if (wf32 > 32'(MAX_WIDTH)) begin
      width_cfg = CW'(MAX_WIDTH);
    end else begin
      width_cfg = CW'(wf32);
    end
    if (hf32 < 32'd2) begin
      height_cfg = RW'(2);
    end else if (hf32 > 32'(MAX_HEIGHT)) begin
      height_cfg = RW'(MAX_HEIGHT);
    end else begin
      height_cfg = RW'(hf32);
    end
  end

  assign in_ready    = queue_room;
  assign accept      = in_valid && in_ready;
  assign draining    = in_row >= height_reg;
  // drain ticks inside a frame are swallowed
  assign live        = accept && !(kind && !draining);
  assign out_row_inc = out_row + RW'(1);
  assign out_col_inc = out_col + CW'(1);
  assign in_col_inc  = in_col + CW'(1);
  assign emit        = (in_row > RW'(1)) || ((in_row == RW'(1)) && (in_col != '0));
  assign last        = emit && (out_row_inc == height_reg) && (out_col_inc == width_reg);

  always_comb begin
    mask.row_top   = out_row != '0;
    mask.row_bot   = out_row_inc < height_reg;
    mask.col_left  = out_col != '0;
    mask.col_right = out_col_inc < width_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= CW'(RST_W);
      height_reg <= RW'(RST_H);
      in_row     <= '0;
      in_col     <= '0;
      out_row    <= '0;
      out_col    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bblur_pkg::REG_IMAGE_WIDTH:  width_reg  <= width_cfg;
        bblur_pkg::REG_IMAGE_HEIGHT: height_reg <= height_cfg;
      endcase
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (live) begin
      if (last) begin
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
      end else begin
        if (emit) begin
          if (out_col_inc >= width_reg) begin
            out_col <= '0;
            out_row <= out_row_inc;
          end else begin
            out_col <= out_col_inc;
          end
        end
        if (!draining) begin
          if (in_col_inc >= width_reg) begin
            in_col <= '0;
            in_row <= in_row + RW'(1);
          end else begin
            in_col <= in_col_inc;
          end
        end else if (in_col < width_reg) begin
          in_col <= in_col_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= live;
    end
  end

  always_ff @(posedge clk) begin
    if (live) begin
      s1_wr   <= !draining;
      s1_col  <= in_col[AW-1:0];
      s1_pix  <= '{red: in_red, green: in_green, blue: in_blue};
      s1_emit <= emit;
      s1_last <= last;
      s1_mask <= mask;
    end
  end

  // read at accept, write back the shifted column in the following cycle
  always_ff @(posedge clk) begin
    if (live) begin
      line_rdata <= line_mem[in_col[AW-1:0]];
    end
    if (s1_valid && s1_wr) begin
      line_mem[s1_col] <= {line_rdata[PW-1:0], s1_pix};
    end
  end

  assign push = s1_valid;

  always_comb begin
    push_data.top  = line_rdata[2*PW-1:PW];
    push_data.mid  = line_rdata[PW-1:0];
    push_data.bot  = s1_pix;
    push_data.emit = s1_emit;
    push_data.last = s1_last;
    push_data.mask = s1_mask;
  end

  a_out_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_col < width_reg)
    else $error("output column beyond frame width");

  a_in_row_bounded: assert property (@(posedge clk) disable iff (rst)
    in_row <= height_reg)
    else $error("input row beyond drain row");

endmodule

/* hw/rtl/bblur_queue.sv */
// ----------------------------------------------------------------------------
// bblur_queue: short queue between front end and back end
// Holds classified column beats; reports room for one beat still in flight.
// ----------------------------------------------------------------------------
module bblur_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bblur_pkg::col_entry_t push_data,
  input  logic                  pop,
  output bblur_pkg::col_entry_t head,
  output logic                  not_empty,
  output logic                  room
);

  localparam int DEPTH = bblur_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bblur_pkg::col_entry_t slots [DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;

  assign head      = slots[rd_ptr];
  assign not_empty = count != '0;
  // front end has one beat in flight behind the accept
  assign room      = count <= CNT_W'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && (count == CNT_W'(DEPTH))))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && (count == '0)))
    else $error("pop from empty queue");

endmodule

/* hw/rtl/bblur_back.sv */
// ----------------------------------------------------------------------------
// bblur_back: window, neighbourhood sums and rounded mean
// Shifts the 3x3 window per beat, sums masked taps, divides by 4, 6 or 9.
// ----------------------------------------------------------------------------
module bblur_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  restart,
  input  logic                  q_valid,
  input  bblur_pkg::col_entry_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic                  frame_end
);

  localparam int SW = bblur_pkg::SUM_W;
  localparam int MW = bblur_pkg::SUM_W + bblur_pkg::RECIP_W;
  localparam int RS = bblur_pkg::RECIP_SHIFT;

  function automatic logic [7:0] pick_chan(bblur_pkg::pix_t p, logic [1:0] sel);
    logic [7:0] v;
    unique case (sel)
      2'd0:    v = p.red;
      2'd1:    v = p.green;
      default: v = p.blue;
    endcase
    return v;
  endfunction

  bblur_pkg::pix_t win_old [3];
  bblur_pkg::pix_t win_new [3];
  bblur_pkg::pix_t cols [3][3];
  logic            col_on [3];
  logic            row_on [3];
  logic [SW-1:0]   sum_next [3];

  logic          a_valid;
  logic          a_emit;
  logic          a_last;
  logic          a_rows3;
  logic          a_cols3;
  logic [SW-1:0] a_sum [3];

  logic          out_take;
  logic          a_moves;
  logic          a_free;
  logic [SW-1:0] num [3];
  logic [MW-1:0] prod [3];
  logic [7:0]    quot [3];

  assign out_take = !out_valid || out_ready;
  assign a_moves  = a_valid && (!a_emit || out_take);
  assign a_free   = !a_valid || a_moves;
  assign q_pop    = q_valid && a_free;

  always_comb begin
    cols[0]   = win_old;
    cols[1]   = win_new;
    cols[2][0] = q_head.top;
    cols[2][1] = q_head.mid;
    cols[2][2] = q_head.bot;
    col_on[0] = q_head.mask.col_left;
    col_on[1] = 1'b1;
    col_on[2] = q_head.mask.col_right;
    row_on[0] = q_head.mask.row_top;
    row_on[1] = 1'b1;
    row_on[2] = q_head.mask.row_bot;
    for (int k = 0; k < 3; k++) begin
      sum_next[k] = '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          if (col_on[c] && row_on[r]) begin
            sum_next[k] = sum_next[k] + SW'(pick_chan(cols[c][r], 2'(k)));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int i = 0; i < 3; i++) begin
        win_old[i] <= '0;
        win_new[i] <= '0;
      end
    end else if (q_pop) begin
      if (q_head.last) begin
        for (int i = 0; i < 3; i++) begin
          win_old[i] <= '0;
          win_new[i] <= '0;
        end
      end else begin
        win_old    <= win_new;
        win_new[0] <= q_head.top;
        win_new[1] <= q_head.mid;
        win_new[2] <= q_head.bot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (q_pop) begin
      a_valid <= 1'b1;
    end else if (a_moves) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_emit  <= q_head.emit;
      a_last  <= q_head.last;
      a_rows3 <= q_head.mask.row_top && q_head.mask.row_bot;
      a_cols3 <= q_head.mask.col_left && q_head.mask.col_right;
      a_sum   <= sum_next;
    end
  end

  // round half up: (sum + n/2) / n, n in {4, 6, 9}
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case ({a_rows3, a_cols3})
        2'b00: begin
          num[k]  = a_sum[k] + SW'(2);
          prod[k] = '0;
          quot[k] = num[k][9:2];
        end
        2'b11: begin
          num[k]  = a_sum[k] + SW'(4);
          prod[k] = MW'(num[k]) * MW'(bblur_pkg::RECIP9);
          quot[k] = prod[k][RS+7:RS];
        end
        2'b01, 2'b10: begin
          num[k]  = a_sum[k] + SW'(3);
          prod[k] = MW'(num[k]) * MW'(bblur_pkg::RECIP6);
          quot[k] = prod[k][RS+7:RS];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_valid && a_emit && out_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_emit && out_take) begin
      out_red   <= quot[0];
      out_green <= quot[1];
      out_blue  <= quot[2];
      frame_end <= a_last;
    end
  end

endmodule

/* hw/rtl/box_blur_3x3_edge_normalized.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_normalized: streaming 3x3 box blur, RGB888
// Rounded mean over the in-image 3x3 neighbourhood (4, 6 or 9 pixels).
//
//   channel  dir  beat                                handshake
//   in       in   kind, in_red, in_green, in_blue     in_valid / in_ready
//   out      out  out_red, out_green, out_blue,       out_valid / out_ready
//                 frame_end
//   cfg      in   cfg_addr, cfg_wdata                 cfg_we
//
// One beat per cycle sustained while the queue has room; set by the dual-port
// column store, which takes one read and one write each cycle.
// A result passes the front-end stage, the queue, the sum stage and the output
// register, w+1 beats behind its centre pixel; w+1 drain beats close a frame.
// Reset is synchronous; the column store needs no clearing pass.
// The front end stalls only when the four-entry queue is nearly full.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_normalized #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bblur_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             kind,
  input  logic [7:0]                       in_red,
  input  logic [7:0]                       in_green,
  input  logic [7:0]                       in_blue,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic                             frame_end
);

  logic                  push;
  bblur_pkg::col_entry_t push_data;
  logic                  pop;
  bblur_pkg::col_entry_t head;
  logic                  not_empty;
  logic                  room;

  bblur_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .queue_room (room),
    .push       (push),
    .push_data  (push_data)
  );

  bblur_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room      (room)
  );

  bblur_back u_back (
    .clk       (clk),
    .rst       (rst),
    .restart   (cfg_we),
    .q_valid   (not_empty),
    .q_head    (head),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .frame_end (frame_end)
  );

endmodule

/* sim/box_blur_3x3_edge_normalized_tb.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_normalized_tb: self-checking bench for the 3x3 box blur
// Streams whole and cut-short frames of random RGB pixels through the blur
// under random output back-pressure and input gaps. A line-buffered shadow
// of the window predicts each rounded neighbourhood mean and the frame_end
// mark, and every output beat is compared with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_normalized_tb;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    bblur_pkg::pix_t px;
    logic            frame_end;
  } blurred_t;

  class blur_window_track;
    int unsigned     width, height;
    bblur_pkg::pix_t upper[MAX_W];
    bblur_pkg::pix_t lower[MAX_W];
    bblur_pkg::pix_t win[6];      // [0..2] newer column, [3..5] older column
    int unsigned     in_row, in_col, out_row, out_col;
    blurred_t        blurred_due[$];
    int unsigned     errors, checked, frames;

    function new();
      width  = bblur_pkg::RESET_WIDTH;
      height = bblur_pkg::RESET_HEIGHT;
      foreach (upper[i]) begin
        upper[i] = '0;
        lower[i] = '0;
      end
      errors  = 0;
      checked = 0;
      frames  = 0;
      restart();
    endfunction

    function void restart();
      foreach (win[i]) win[i] = '0;
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void write_reg(logic [bblur_pkg::CFG_ADDR_W-1:0] addr,
                            logic [bblur_pkg::CFG_DATA_W-1:0] data);
      if (addr == bblur_pkg::REG_IMAGE_WIDTH) begin
        width = clamp(data[bblur_pkg::WIDTH_FIELD_W-1:0], 2, MAX_W);
      end else if (addr == bblur_pkg::REG_IMAGE_HEIGHT) begin
        height = clamp(data[bblur_pkg::HEIGHT_FIELD_W-1:0], 2, MAX_H);
      end
      restart();
    endfunction

    function logic [7:0] mean_half_up(int unsigned sum, int unsigned n);
      return 8'((2 * sum + n) / (2 * n));
    endfunction

    // returns 1 unless the beat is a drain tick that the block ignores
    function bit absorb_beat(bit drain_kind, bblur_pkg::pix_t px);
      int unsigned     w = width;
      int unsigned     h = height;
      int unsigned     col = in_col;
      bit              draining = in_row >= h;
      bit              tail = 1'b0;
      bblur_pkg::pix_t fresh[3];
      bblur_pkg::pix_t cols[3][3];
      bit              rv[3], cv[3];
      int unsigned     n, sr, sg, sb;
      blurred_t        res;
      if (drain_kind && !draining) return 1'b0;
      fresh = '{'0, '0, '0};
      if (col < w) begin
        fresh[0] = upper[col];
        fresh[1] = lower[col];
        if (!draining) begin
          fresh[2]   = px;
          upper[col] = lower[col];
          lower[col] = px;
        end
      end
      if (in_row * w + col >= w + 1) begin
        rv = '{out_row > 0, 1'b1, out_row + 1 < h};
        cv = '{out_col > 0, 1'b1, out_col + 1 < w};
        cols[0] = '{win[3], win[4], win[5]};
        cols[1] = '{win[0], win[1], win[2]};
        cols[2] = fresh;
        n  = 0;
        sr = 0;
        sg = 0;
        sb = 0;
        for (int c = 0; c < 3; c++) begin
          for (int r = 0; r < 3; r++) begin
            if (cv[c] && rv[r]) begin
              sr += cols[c][r].red;
              sg += cols[c][r].green;
              sb += cols[c][r].blue;
              n++;
            end
          end
        end
        res.px.red    = mean_half_up(sr, n);
        res.px.green  = mean_half_up(sg, n);
        res.px.blue   = mean_half_up(sb, n);
        tail          = (out_row + 1 == h) && (out_col + 1 == w);
        res.frame_end = tail;
        blurred_due.push_back(res);
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
      win[3] = win[0];
      win[4] = win[1];
      win[5] = win[2];
      win[0] = fresh[0];
      win[1] = fresh[1];
      win[2] = fresh[2];
      if (!draining) begin
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
      end else if (col < w) begin
        in_col++;
      end
      if (tail) restart();
      return 1'b1;
    endfunction

    function void match_blurred(bblur_pkg::pix_t got, logic got_end);
      blurred_t want;
      if (blurred_due.size() == 0) begin
        $error("output beat with nothing expected: rgb %h end %b", got, got_end);
        errors++;
        return;
      end
      want = blurred_due.pop_front();
      checked++;
      if (got.red !== want.px.red) begin
        $error("out_red: expected %0d, got %0d", want.px.red, got.red);
        errors++;
      end
      if (got.green !== want.px.green) begin
        $error("out_green: expected %0d, got %0d", want.px.green, got.green);
        errors++;
      end
      if (got.blue !== want.px.blue) begin
        $error("out_blue: expected %0d, got %0d", want.px.blue, got.blue);
        errors++;
      end
      if (got_end !== want.frame_end) begin
        $error("frame_end: expected %0b, got %0b", want.frame_end, got_end);
        errors++;
      end
      if (want.frame_end) frames++;
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [bblur_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             kind = 1'b0;
  logic [7:0]                       in_red = '0;
  logic [7:0]                       in_green = '0;
  logic [7:0]                       in_blue = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [7:0]                       out_red;
  logic [7:0]                       out_green;
  logic [7:0]                       out_blue;
  logic                             frame_end;

  blur_window_track blur = new();
  bit               calm = 1'b0;
  bit               in_quiet = 1'b0;
  int unsigned      beats_counted = 0;
  int unsigned      reg_writes = 0;

  box_blur_3x3_edge_normalized DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .frame_end (frame_end)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      blur.match_blurred({out_red, out_green, out_blue}, frame_end);
    end
  end

  // output back-pressure: stall bursts, with quiet stretches
  initial begin
    int unsigned turn;
    bit          out_quiet;
    turn      = 0;
    out_quiet = 1'b0;
    forever begin
      @(negedge clk);
      if (turn % 48 == 0) out_quiet = ($urandom_range(0, 2) == 0);
      turn++;
      if (!calm && !out_quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic bblur_pkg::pix_t pick_pixel();
    return {pick_channel(), pick_channel(), pick_channel()};
  endfunction

  task automatic send_beat(input bit k, input bblur_pkg::pix_t px);
    int unsigned gap;
    gap = (!calm && !in_quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    in_red   <= px.red;
    in_green <= px.green;
    in_blue  <= px.blue;
    do @(posedge clk); while (!in_ready);
    if (blur.absorb_beat(k, px)) beats_counted++;
  endtask

  // drop valid, wait for every expected beat, then let the pipe run dry
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (blur.blurred_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bblur_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [bblur_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    blur.write_reg(addr, data);
    reg_writes++;
  endtask

  // npix pixels with stray ticks; a whole frame also gets its drain beats
  task automatic stream_frame(input int unsigned npix);
    int unsigned w;
    w = blur.width;
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(0, 9) == 0) send_beat(1'b1, pick_pixel());
      send_beat(1'b0, pick_pixel());
    end
    if (npix == blur.width * blur.height) begin
      for (int unsigned i = 0; i <= w; i++) begin
        send_beat($urandom_range(0, 5) != 0, pick_pixel());
      end
      if ($urandom_range(0, 7) == 0) send_beat(1'b1, pick_pixel());
    end
  endtask

  initial begin
    int unsigned target, w, h, spin;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // both below range: clamp to a 2x2 frame
    write_reg(bblur_pkg::REG_IMAGE_WIDTH, '0);
    write_reg(bblur_pkg::REG_IMAGE_HEIGHT, 13'd1);
    send_beat(1'b0, {8'hFF, 8'h00, 8'hFF});
    send_beat(1'b1, 24'hFFFFFF);             // stray tick mid-frame
    send_beat(1'b0, {8'h00, 8'hFF, 8'h00});
    send_beat(1'b0, 24'hFFFFFF);
    send_beat(1'b0, 24'h000000);
    send_beat(1'b1, 24'h000000);
    send_beat(1'b0, {8'h5A, 8'hA5, 8'h3C});  // pixel while draining
    send_beat(1'b1, 24'hFFFFFF);
    send_beat(1'b1, 24'h000000);             // new frame: ignored
    settle();

    // 3x3: corners, edges and centre, half-way rounding
    write_reg(bblur_pkg::REG_IMAGE_WIDTH, 13'd3);
    write_reg(bblur_pkg::REG_IMAGE_HEIGHT, 13'd3);
    send_beat(1'b0, {8'd2, 8'd1, 8'd255});
    send_beat(1'b0, {8'd0, 8'd0, 8'd255});
    send_beat(1'b0, {8'd1, 8'd2, 8'd0});
    send_beat(1'b0, {8'd0, 8'd0, 8'd255});
    send_beat(1'b0, {8'd3, 8'd4, 8'd254});
    send_beat(1'b0, {8'd255, 8'd0, 8'd1});
    send_beat(1'b0, {8'd1, 8'd255, 8'd0});
    send_beat(1'b0, {8'd0, 8'd0, 8'd128});
    send_beat(1'b0, {8'd255, 8'd255, 8'd255});
    repeat (4) send_beat(1'b1, 24'h000000);
    settle();

    // widest frame, width write above range, cut short in its first row
    write_reg(bblur_pkg::REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(bblur_pkg::REG_IMAGE_HEIGHT, '0);
    stream_frame(64);
    settle();

    // tallest frame, cut short; the next write restarts it
    write_reg(bblur_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
    write_reg(bblur_pkg::REG_IMAGE_WIDTH, 13'd2);
    stream_frame(40);
    settle();
    write_reg(bblur_pkg::REG_IMAGE_HEIGHT, 13'd4096);

    target = beats_counted + 660;
    while (beats_counted < target) begin
      if (target - beats_counted < 150) calm = 1'b1;
      in_quiet = ($urandom_range(0, 3) == 0);
      if (blur.height > 16 || $urandom_range(0, 2) == 0) begin
        settle();
        case ($urandom_range(0, 7))
          0:       w = $urandom_range(0, 1);
          1:       w = $urandom_range(11, 40);
          default: w = $urandom_range(2, 10);
        endcase
        h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
        if ($urandom_range(0, 3) != 0) write_reg(bblur_pkg::REG_IMAGE_WIDTH, 13'(w));
        write_reg(bblur_pkg::REG_IMAGE_HEIGHT, 13'(h));
      end
      if ($urandom_range(0, 6) == 0) begin
        stream_frame($urandom_range(1, blur.width * blur.height - 1));
        settle();
        write_reg($urandom_range(0, 1) ? bblur_pkg::REG_IMAGE_WIDTH
                                       : bblur_pkg::REG_IMAGE_HEIGHT,
                  13'($urandom_range(2, 8)));
      end else begin
        stream_frame(blur.width * blur.height);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    for (spin = 0; spin < 20000 && blur.blurred_due.size() != 0; spin++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (blur.blurred_due.size() != 0) begin
      $error("%0d expected output beats never arrived", blur.blurred_due.size());
      blur.errors++;
    end

    $display("Drove %0d beats across %0d register writes; checked %0d blurred pixels",
             beats_counted, reg_writes, blur.checked);
    $display("covering %0d complete frames, with %0d mismatches.", blur.frames, blur.errors);
    if (blur.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* box_blur_3x3_edge_normalized.f */
hw/rtl/bblur_pkg.sv
hw/rtl/bblur_front.sv
hw/rtl/bblur_queue.sv
hw/rtl/bblur_back.sv
hw/rtl/box_blur_3x3_edge_normalized.sv
sim/box_blur_3x3_edge_normalized_tb.sv
